// ===== hw/rtl/xrg_pkg.sv =====
// Package for the xoshiro256** random generator unit.
// Holds operation codes, controller states, command/status structs and constants.
// No dependencies.
package xrg_pkg;

  typedef enum logic [1:0] {
    OpSeed    = 2'd0,
    OpUniform = 2'd1,
    OpRange   = 2'd2,
    OpNone    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StSeedMix1,
    StSeedMulA,
    StSeedMix2,
    StSeedMulB,
    StSeedStore,
    StDraw,
    StNorm,
    StDivide,
    StDone
  } state_e;

  localparam logic [63:0] GoldenStep = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MixMulA    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MixMulB    = 64'h94D049BB133111EB;
  localparam logic [63:0] ResetW0    = 64'h180EC6D33CFD0ABA;
  localparam logic [63:0] ResetW1    = 64'hD5A61266F0C9392C;
  localparam logic [63:0] ResetW2    = 64'hA9582618E03FC9AA;
  localparam logic [63:0] ResetW3    = 64'h39ABDC4529B1661C;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture operand, clear result
    logic seed_step;   // add golden step, first xor-shift, clear product
    logic mul_step;    // one 16-bit digit of a mixing multiply
    logic mul_sel_b;   // multiply by the second mixing constant
    logic seed_mix2;   // second xor-shift, clear product
    logic seed_store;  // finish mix, store word
    logic draw;        // advance generator
    logic norm_step;   // one normalization step
    logic div_init;    // start remainder divider
    logic div_step;    // one divider bit
    logic uni_finish;  // assemble double
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bound_pos;
    logic norm_done;
    logic div_done;
    logic seed_last;
    logic mul_last;
  } status_t;

endpackage

// ===== hw/rtl/xrg_datapath.sv =====
// Datapath of the xoshiro256** generator unit: state words, SplitMix64
// mixer, normalizer and bit-serial remainder divider. Uses xrg_pkg.
module xrg_datapath import xrg_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [63:0]   operand_i,
  input  cmd_t          cmd_i,
  output status_t       status_o,
  output logic [63:0]   value_o
);

  logic [63:0] w_q [4];
  logic [63:0] w_d [4];
  logic [63:0] z_q, z_d;       // seed chain, also multiplier operand
  logic [63:0] acc_q, acc_d;   // draw value / remainder / mix product
  logic [63:0] quo_q, quo_d;   // dividend shifting out
  logic [63:0] bnd_q, bnd_d;
  logic [6:0]  cnt_q, cnt_d;   // divider bit count, normalize exponent or digit index
  logic [1:0]  idx_q, idx_d;
  logic [63:0] res_q, res_d;

  logic [63:0] out_mul, sh17, t2, t3, t1, t0;
  logic [64:0] rem_sh;
  logic [63:0] zx;
  logic [63:0] mul_const;
  logic [15:0] mul_digit;
  logic [79:0] mul_pp;

  // Generator advance.
  always_comb begin
    out_mul = w_q[1] * 64'd5;
    out_mul = {out_mul[56:0], out_mul[63:57]} * 64'd9;
    sh17    = w_q[1] << 17;
    t2      = w_q[2] ^ w_q[0];
    t3      = w_q[3] ^ w_q[1];
    t1      = w_q[1] ^ t2;
    t0      = w_q[0] ^ t3;
  end

  // Mixing multiply: one 16-bit digit of the constant per cycle.
  always_comb begin
    mul_const = cmd_i.mul_sel_b ? MixMulB : MixMulA;
    mul_digit = mul_const[{cnt_q[1:0], 4'd0} +: 16];
    mul_pp    = {16'd0, z_q} * {64'd0, mul_digit};
  end

  assign rem_sh = {acc_q, quo_q[63]};

  // Next-state logic for all datapath registers.
  always_comb begin
    w_d   = w_q;
    z_d   = z_q;
    acc_d = acc_q;
    quo_d = quo_q;
    bnd_d = bnd_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    res_d = res_q;
    zx    = 64'd0;
    if (cmd_i.load) begin
      z_d   = operand_i;
      bnd_d = operand_i;
      idx_d = 2'd0;
      res_d = 64'd0;
    end
    if (cmd_i.seed_step) begin
      zx    = z_q + GoldenStep;
      z_d   = zx ^ (zx >> 30);
      acc_d = 64'd0;
      cnt_d = 7'd0;
    end
    // Accumulate one shifted partial product.
    if (cmd_i.mul_step) begin
      acc_d = acc_q + (mul_pp[63:0] << {cnt_q[1:0], 4'd0});
      cnt_d = cnt_q + 7'd1;
    end
    if (cmd_i.seed_mix2) begin
      z_d   = acc_q ^ (acc_q >> 27);
      acc_d = 64'd0;
      cnt_d = 7'd0;
    end
    // The second product, before its last xor-shift, carries on as the next chain value.
    if (cmd_i.seed_store) begin
      w_d[idx_q] = acc_q ^ (acc_q >> 31);
      z_d        = acc_q;
      idx_d      = idx_q + 2'd1;
    end
    if (cmd_i.draw) begin
      w_d[0] = t0;
      w_d[1] = t1;
      w_d[2] = t2 ^ sh17;
      w_d[3] = {t3[18:0], t3[63:19]};
      acc_d  = {11'd0, out_mul[63:11]};
      quo_d  = out_mul;
      cnt_d  = 7'd52;
    end
    // Normalize: shift left until bit 52 is set, lowering the exponent.
    if (cmd_i.norm_step && !acc_q[52] && acc_q != 64'd0) begin
      acc_d = acc_q << 1;
      cnt_d = cnt_q - 7'd1;
    end
    if (cmd_i.uni_finish) begin
      if (acc_q == 64'd0) res_d = 64'd0;
      else res_d = {1'b0, 11'(11'd970 + 11'(cnt_q)), acc_q[51:0]};
    end
    if (cmd_i.div_init) begin
      acc_d = 64'd0;
      cnt_d = 7'd64;
    end
    // Restoring remainder step, one dividend bit per cycle.
    if (cmd_i.div_step) begin
      quo_d = quo_q << 1;
      cnt_d = cnt_q - 7'd1;
      if (rem_sh >= {1'b0, bnd_q}) acc_d = 64'(rem_sh - {1'b0, bnd_q});
      else acc_d = rem_sh[63:0];
      if (cnt_q == 7'd1) res_d = (rem_sh >= {1'b0, bnd_q}) ?
                                 64'(rem_sh - {1'b0, bnd_q}) : rem_sh[63:0];
    end
  end

  // State words reset to the fixed constants.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q[0] <= ResetW0;
      w_q[1] <= ResetW1;
      w_q[2] <= ResetW2;
      w_q[3] <= ResetW3;
      idx_q  <= 2'd0;
      cnt_q  <= 7'd0;
    end else begin
      w_q   <= w_d;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    z_q   <= z_d;
    acc_q <= acc_d;
    quo_q <= quo_d;
    bnd_q <= bnd_d;
    res_q <= res_d;
  end

  assign status_o.bound_pos = !bnd_q[63] && bnd_q != 64'd0;
  assign status_o.norm_done = acc_q[52] || acc_q == 64'd0;
  assign status_o.div_done  = cnt_q == 7'd1;
  assign status_o.seed_last = idx_q == 2'd3;
  assign status_o.mul_last  = cnt_q[1:0] == 2'd3;
  assign value_o = res_q;

endmodule

// ===== hw/rtl/xrg_controller.sv =====
// Controller of the xoshiro256** generator unit: sequences seed, uniform
// and range requests. Uses xrg_pkg.
module xrg_controller import xrg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic [1:0] operation_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o,
  output logic    done_o
);

  state_e state_q, state_d;
  op_e    op_q, op_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      op_q    <= OpNone;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          op_d = op_e'(operation_i);
          case (op_e'(operation_i))
            OpSeed:    state_d = StSeedMix1;
            OpUniform: state_d = StDraw;
            OpRange:   state_d = StDraw;
            default:   state_d = StDone;
          endcase
        end
      end
      StSeedMix1: begin
        cmd_o.seed_step = 1'b1;
        state_d = StSeedMulA;
      end
      // Four digit steps of the first mixing multiply.
      StSeedMulA: begin
        cmd_o.mul_step = 1'b1;
        if (status_i.mul_last) state_d = StSeedMix2;
      end
      StSeedMix2: begin
        cmd_o.seed_mix2 = 1'b1;
        state_d = StSeedMulB;
      end
      // Four digit steps of the second mixing multiply.
      StSeedMulB: begin
        cmd_o.mul_step  = 1'b1;
        cmd_o.mul_sel_b = 1'b1;
        if (status_i.mul_last) state_d = StSeedStore;
      end
      StSeedStore: begin
        cmd_o.seed_store = 1'b1;
        state_d = status_i.seed_last ? StDone : StSeedMix1;
      end
      StDraw: begin
        if (op_q == OpUniform) begin
          cmd_o.draw = 1'b1;
          state_d = StNorm;
        end else if (status_i.bound_pos) begin
          cmd_o.draw = 1'b1;
          state_d = StDivide;
        end else begin
          state_d = StDone;
        end
      end
      StNorm: begin
        if (status_i.norm_done) begin
          cmd_o.uni_finish = 1'b1;
          state_d = StDone;
        end else begin
          cmd_o.norm_step = 1'b1;
        end
      end
      StDivide: begin
        // First cycle clears the remainder; the dividend sits in place.
        if (op_q == OpRange) begin
          cmd_o.div_init = 1'b1;
          op_d = OpNone;
        end else begin
          cmd_o.div_step = 1'b1;
          if (status_i.div_done) state_d = StDone;
        end
      end
      StDone: begin
        done_o  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// ===== hw/rtl/xoshiro256ss_random_generator_unit.sv =====
// Top level of the xoshiro256** random generator unit.
// Instantiates xrg_controller and xrg_datapath; uses xrg_pkg.
//
// Usage: raise start_i with operation_i and operand_i while busy_o is low;
// that edge is the transfer of a request. Exactly one result follows, shown
// on value_o for one cycle with valid_o high; the receiver cannot stall.
// busy_o falls the cycle after the result, when a new transfer can follow.
// Operation 0 seeds the four state words with the SplitMix64 mixer, each
// word by an add and xor-shift, a multiply by the first constant in four
// 16-bit digit steps, a second xor-shift, a multiply by the second constant
// in four 16-bit digit steps, and a final xor-shift and store; result zero.
// Operation 1 advances the generator and returns a double in [0,1),
// normalized by a shifter that moves one bit per cycle. Operation 2 returns
// the draw modulo the bound from the bit-serial remainder divider (64 steps);
// a bound of zero or below gives zero without advancing. Code 3 gives zero.
// Reset loads the fixed xoshiro start words.
module xoshiro256ss_random_generator_unit import xrg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic signed [63:0] operand_i,
  output logic        valid_o,
  output logic [63:0] value_o
);

  cmd_t    cmd;
  status_t status;

  xrg_controller u_ctrl (
    .clk_i, .rst_ni, .start_i, .operation_i,
    .status_i(status), .cmd_o(cmd), .busy_o, .done_o(valid_o)
  );

  xrg_datapath u_dp (
    .clk_i, .rst_ni, .operand_i(operand_i),
    .cmd_i(cmd), .status_o(status), .value_o
  );

endmodule
